/* sv/aes_round_transform_unit_assert.svh */
// Assertion macros for the AES round transform unit
`ifndef AES_ROUND_TRANSFORM_UNIT_ASSERT_SVH
`define AES_ROUND_TRANSFORM_UNIT_ASSERT_SVH

`ifndef ASSERT_OFF
// implication checked on every clock, off during reset
`define ARTU_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);
// next-cycle implication
`define ARTU_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);
`else
`define ARTU_ASSERT_IMP(label, clk, rst_n, ante, cons, msg)
`define ARTU_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg)
`endif

`endif

/* sv/artu_pkg.sv */
package artu_pkg;

	typedef enum logic [2:0] {
		KIND_SHIFT_ROWS     = 3'd0,
		KIND_INV_SHIFT_ROWS = 3'd1,
		KIND_MIX_COLUMNS    = 3'd2,
		KIND_INV_MIX        = 3'd3,
		KIND_SUB_BYTES      = 3'd4,
		KIND_INV_SUB_BYTES  = 3'd5,
		KIND_ADD_KEY        = 3'd6
	} kind_t;

	typedef struct packed {
		logic [2:0]  kind;
		logic [63:0] state_hi;
		logic [63:0] state_lo;
		logic [63:0] key_hi;
		logic [63:0] key_lo;
	} item_in_t;

	typedef struct packed {
		logic [63:0] result_hi;
		logic [63:0] result_lo;
	} item_out_t;

	typedef logic [7:0] byte_t;

	localparam byte_t SBOX [256] = '{
		8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
		8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
		8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
		8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
		8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
		8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
		8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
		8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
		8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
		8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
		8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
		8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
		8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
		8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
		8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
		8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16
	};

	localparam byte_t INV_SBOX [256] = '{
		8'h52,8'h09,8'h6a,8'hd5,8'h30,8'h36,8'ha5,8'h38,8'hbf,8'h40,8'ha3,8'h9e,8'h81,8'hf3,8'hd7,8'hfb,
		8'h7c,8'he3,8'h39,8'h82,8'h9b,8'h2f,8'hff,8'h87,8'h34,8'h8e,8'h43,8'h44,8'hc4,8'hde,8'he9,8'hcb,
		8'h54,8'h7b,8'h94,8'h32,8'ha6,8'hc2,8'h23,8'h3d,8'hee,8'h4c,8'h95,8'h0b,8'h42,8'hfa,8'hc3,8'h4e,
		8'h08,8'h2e,8'ha1,8'h66,8'h28,8'hd9,8'h24,8'hb2,8'h76,8'h5b,8'ha2,8'h49,8'h6d,8'h8b,8'hd1,8'h25,
		8'h72,8'hf8,8'hf6,8'h64,8'h86,8'h68,8'h98,8'h16,8'hd4,8'ha4,8'h5c,8'hcc,8'h5d,8'h65,8'hb6,8'h92,
		8'h6c,8'h70,8'h48,8'h50,8'hfd,8'hed,8'hb9,8'hda,8'h5e,8'h15,8'h46,8'h57,8'ha7,8'h8d,8'h9d,8'h84,
		8'h90,8'hd8,8'hab,8'h00,8'h8c,8'hbc,8'hd3,8'h0a,8'hf7,8'he4,8'h58,8'h05,8'hb8,8'hb3,8'h45,8'h06,
		8'hd0,8'h2c,8'h1e,8'h8f,8'hca,8'h3f,8'h0f,8'h02,8'hc1,8'haf,8'hbd,8'h03,8'h01,8'h13,8'h8a,8'h6b,
		8'h3a,8'h91,8'h11,8'h41,8'h4f,8'h67,8'hdc,8'hea,8'h97,8'hf2,8'hcf,8'hce,8'hf0,8'hb4,8'he6,8'h73,
		8'h96,8'hac,8'h74,8'h22,8'he7,8'had,8'h35,8'h85,8'he2,8'hf9,8'h37,8'he8,8'h1c,8'h75,8'hdf,8'h6e,
		8'h47,8'hf1,8'h1a,8'h71,8'h1d,8'h29,8'hc5,8'h89,8'h6f,8'hb7,8'h62,8'h0e,8'haa,8'h18,8'hbe,8'h1b,
		8'hfc,8'h56,8'h3e,8'h4b,8'hc6,8'hd2,8'h79,8'h20,8'h9a,8'hdb,8'hc0,8'hfe,8'h78,8'hcd,8'h5a,8'hf4,
		8'h1f,8'hdd,8'ha8,8'h33,8'h88,8'h07,8'hc7,8'h31,8'hb1,8'h12,8'h10,8'h59,8'h27,8'h80,8'hec,8'h5f,
		8'h60,8'h51,8'h7f,8'ha9,8'h19,8'hb5,8'h4a,8'h0d,8'h2d,8'he5,8'h7a,8'h9f,8'h93,8'hc9,8'h9c,8'hef,
		8'ha0,8'he0,8'h3b,8'h4d,8'hae,8'h2a,8'hf5,8'hb0,8'hc8,8'heb,8'hbb,8'h3c,8'h83,8'h53,8'h99,8'h61,
		8'h17,8'h2b,8'h04,8'h7e,8'hba,8'h77,8'hd6,8'h26,8'he1,8'h69,8'h14,8'h63,8'h55,8'h21,8'h0c,8'h7d
	};

	// multiply by x modulo 0x11B
	function automatic byte_t xtime(input byte_t a);
		return {a[6:0], 1'b0} ^ (a[7] ? 8'h1b : 8'h00);
	endfunction

	// constant multiplies used by the column mixes
	function automatic byte_t mul2(input byte_t a);
		return xtime(a);
	endfunction

	function automatic byte_t mul3(input byte_t a);
		return xtime(a) ^ a;
	endfunction

	function automatic byte_t mul9(input byte_t a);
		return xtime(xtime(xtime(a))) ^ a;
	endfunction

	function automatic byte_t mul11(input byte_t a);
		return xtime(xtime(xtime(a))) ^ xtime(a) ^ a;
	endfunction

	function automatic byte_t mul13(input byte_t a);
		return xtime(xtime(xtime(a))) ^ xtime(xtime(a)) ^ a;
	endfunction

	function automatic byte_t mul14(input byte_t a);
		return xtime(xtime(xtime(a))) ^ xtime(xtime(a)) ^ xtime(a);
	endfunction

endpackage

/* sv/aes_round_transform_unit.sv */
// AES round transform unit: applies one AES-128 state transformation per item
// (ShiftRows, InvShiftRows, MixColumns, InvMixColumns, SubBytes, InvSubBytes,
// AddRoundKey). An item is taken whenever start is high; busy is always low,
// so a new item enters every cycle. The result is driven with done high once
// the item has passed the input register and then the result register. It
// stays for that one cycle only: the receiver must capture it then, as there
// is no way to hold results. Kind code 7 passes the state through unchanged.
`include "aes_round_transform_unit_assert.svh"

module aes_round_transform_unit (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 start,
	output logic                 busy,
	input  artu_pkg::item_in_t   item_in,
	output logic                 done,
	output artu_pkg::item_out_t  item_out
);
	import artu_pkg::*;

	item_in_t    in_s1;
	logic        vld_s1;
	item_out_t   res_s2;
	logic        vld_s2;
	byte_t       s [16];
	byte_t       k [16];
	byte_t       r [16];

	assign busy = 1'b0;

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else begin
			vld_s1 <= start;
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			in_s1 <= item_in;
		end
	end

	// unpack bytes, byte 0 in the top bits
	always_comb begin
		for (int i = 0; i < 8; i++) begin
			s[i]     = in_s1.state_hi[63 - 8 * i -: 8];
			s[i + 8] = in_s1.state_lo[63 - 8 * i -: 8];
			k[i]     = in_s1.key_hi[63 - 8 * i -: 8];
			k[i + 8] = in_s1.key_lo[63 - 8 * i -: 8];
		end
	end

	// transform selected by kind
	always_comb begin
		for (int i = 0; i < 16; i++) begin
			r[i] = s[i];
		end
		case (in_s1.kind)
			KIND_SHIFT_ROWS: begin
				for (int c = 0; c < 4; c++) begin
					for (int w = 0; w < 4; w++) begin
						r[c * 4 + w] = s[((c + w) % 4) * 4 + w];
					end
				end
			end
			KIND_INV_SHIFT_ROWS: begin
				for (int c = 0; c < 4; c++) begin
					for (int w = 0; w < 4; w++) begin
						r[c * 4 + w] = s[((c + 4 - w) % 4) * 4 + w];
					end
				end
			end
			KIND_MIX_COLUMNS: begin
				for (int c = 0; c < 4; c++) begin
					r[c*4]   = mul2(s[c*4]) ^ mul3(s[c*4+1]) ^ s[c*4+2] ^ s[c*4+3];
					r[c*4+1] = s[c*4] ^ mul2(s[c*4+1]) ^ mul3(s[c*4+2]) ^ s[c*4+3];
					r[c*4+2] = s[c*4] ^ s[c*4+1] ^ mul2(s[c*4+2]) ^ mul3(s[c*4+3]);
					r[c*4+3] = mul3(s[c*4]) ^ s[c*4+1] ^ s[c*4+2] ^ mul2(s[c*4+3]);
				end
			end
			KIND_INV_MIX: begin
				for (int c = 0; c < 4; c++) begin
					r[c*4]   = mul14(s[c*4]) ^ mul11(s[c*4+1])
						^ mul13(s[c*4+2]) ^ mul9(s[c*4+3]);
					r[c*4+1] = mul9(s[c*4]) ^ mul14(s[c*4+1])
						^ mul11(s[c*4+2]) ^ mul13(s[c*4+3]);
					r[c*4+2] = mul13(s[c*4]) ^ mul9(s[c*4+1])
						^ mul14(s[c*4+2]) ^ mul11(s[c*4+3]);
					r[c*4+3] = mul11(s[c*4]) ^ mul13(s[c*4+1])
						^ mul9(s[c*4+2]) ^ mul14(s[c*4+3]);
				end
			end
			KIND_SUB_BYTES: begin
				for (int i = 0; i < 16; i++) begin
					r[i] = SBOX[s[i]];
				end
			end
			KIND_INV_SUB_BYTES: begin
				for (int i = 0; i < 16; i++) begin
					r[i] = INV_SBOX[s[i]];
				end
			end
			KIND_ADD_KEY: begin
				for (int i = 0; i < 16; i++) begin
					r[i] = s[i] ^ k[i];
				end
			end
			default: begin
			end
		endcase
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s2 <= 1'b0;
		end else begin
			vld_s2 <= vld_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (vld_s1) begin
			for (int i = 0; i < 8; i++) begin
				res_s2.result_hi[63 - 8 * i -: 8] <= r[i];
				res_s2.result_lo[63 - 8 * i -: 8] <= r[i + 8];
			end
		end
	end

	assign done     = vld_s2;
	assign item_out = res_s2;

	// checks
	`ARTU_ASSERT_NEXT(a_done_follows, clk, arst_n, vld_s1, done, "item lost between stages")
	`ARTU_ASSERT_NEXT(a_no_spurious, clk, arst_n, !vld_s1, !done, "result without item")
	`ARTU_ASSERT_NEXT(a_two_cycles, clk, arst_n, start, ##1 done, "latency is not two cycles")

endmodule

/* tb/sv/aes_transform_checker.sv */
module aes_transform_checker (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 start,
	input  logic                 busy,
	input  artu_pkg::item_in_t   item_in,
	input  logic                 done,
	input  artu_pkg::item_out_t  item_out,
	output int                   fail_count,
	output int                   pending
);
	timeunit 1ns;
	timeprecision 1ps;
	import artu_pkg::*;

	typedef logic [7:0] gf_byte_t;

	item_out_t state_queue[$];

	// GF(2^8) multiply, polynomial 0x11B
	function automatic gf_byte_t gf_mult(input gf_byte_t a, input gf_byte_t b);
		gf_byte_t acc;
		acc = 8'h00;
		for (int i = 0; i < 8; i++) begin
			if (b[i])
				acc ^= a;
			a = {a[6:0], 1'b0} ^ (a[7] ? 8'h1b : 8'h00);
		end
		return acc;
	endfunction

	function automatic gf_byte_t gf_recip(input gf_byte_t x);
		gf_byte_t acc;
		gf_byte_t base;
		acc = 8'h01;
		base = x;
		for (int e = 254; e != 0; e >>= 1) begin
			if (e & 1)
				acc = gf_mult(acc, base);
			base = gf_mult(base, base);
		end
		return acc;
	endfunction

	function automatic gf_byte_t rotl8(input gf_byte_t v, input int n);
		return (v << n) | (v >> (8 - n));
	endfunction

	// computed S-box pair, independent of the package tables
	function automatic gf_byte_t sub_fwd(input gf_byte_t x);
		gf_byte_t b;
		b = gf_recip(x);
		return b ^ rotl8(b, 1) ^ rotl8(b, 2) ^ rotl8(b, 3) ^ rotl8(b, 4) ^ 8'h63;
	endfunction

	function automatic gf_byte_t sub_inv(input gf_byte_t s);
		return gf_recip(rotl8(s, 1) ^ rotl8(s, 3) ^ rotl8(s, 6) ^ 8'h05);
	endfunction

	// transformed state for one item
	function automatic item_out_t transform_state(input item_in_t it);
		gf_byte_t s[16];
		gf_byte_t k[16];
		gf_byte_t r[16];
		logic [127:0] sv;
		logic [127:0] kv;
		logic [127:0] rv;
		gf_byte_t c0, c1, c2, c3;
		sv = {it.state_hi, it.state_lo};
		kv = {it.key_hi, it.key_lo};
		for (int i = 0; i < 16; i++) begin
			s[i] = sv[127 - 8*i -: 8];
			k[i] = kv[127 - 8*i -: 8];
			r[i] = s[i];
		end
		case (it.kind)
			KIND_SHIFT_ROWS:
				for (int c = 0; c < 4; c++)
					for (int w = 0; w < 4; w++)
						r[c*4 + w] = s[((c + w) % 4)*4 + w];
			KIND_INV_SHIFT_ROWS:
				for (int c = 0; c < 4; c++)
					for (int w = 0; w < 4; w++)
						r[c*4 + w] = s[((c + 4 - w) % 4)*4 + w];
			KIND_MIX_COLUMNS:
				for (int c = 0; c < 4; c++) begin
					c0 = s[c*4]; c1 = s[c*4+1]; c2 = s[c*4+2]; c3 = s[c*4+3];
					r[c*4]   = gf_mult(8'h02, c0) ^ gf_mult(8'h03, c1) ^ c2 ^ c3;
					r[c*4+1] = c0 ^ gf_mult(8'h02, c1) ^ gf_mult(8'h03, c2) ^ c3;
					r[c*4+2] = c0 ^ c1 ^ gf_mult(8'h02, c2) ^ gf_mult(8'h03, c3);
					r[c*4+3] = gf_mult(8'h03, c0) ^ c1 ^ c2 ^ gf_mult(8'h02, c3);
				end
			KIND_INV_MIX:
				for (int c = 0; c < 4; c++) begin
					c0 = s[c*4]; c1 = s[c*4+1]; c2 = s[c*4+2]; c3 = s[c*4+3];
					r[c*4]   = gf_mult(8'h0e, c0) ^ gf_mult(8'h0b, c1) ^ gf_mult(8'h0d, c2)
						^ gf_mult(8'h09, c3);
					r[c*4+1] = gf_mult(8'h09, c0) ^ gf_mult(8'h0e, c1) ^ gf_mult(8'h0b, c2)
						^ gf_mult(8'h0d, c3);
					r[c*4+2] = gf_mult(8'h0d, c0) ^ gf_mult(8'h09, c1) ^ gf_mult(8'h0e, c2)
						^ gf_mult(8'h0b, c3);
					r[c*4+3] = gf_mult(8'h0b, c0) ^ gf_mult(8'h0d, c1) ^ gf_mult(8'h09, c2)
						^ gf_mult(8'h0e, c3);
				end
			KIND_SUB_BYTES:
				for (int i = 0; i < 16; i++)
					r[i] = sub_fwd(s[i]);
			KIND_INV_SUB_BYTES:
				for (int i = 0; i < 16; i++)
					r[i] = sub_inv(s[i]);
			KIND_ADD_KEY:
				for (int i = 0; i < 16; i++)
					r[i] = s[i] ^ k[i];
			default: ;  // unused code passes the state through
		endcase
		for (int i = 0; i < 16; i++)
			rv[127 - 8*i -: 8] = r[i];
		return '{result_hi: rv[127:64], result_lo: rv[63:0]};
	endfunction

	assign pending = state_queue.size();

	// predict on accepted items, compare on strobed results
	always @(posedge clk or negedge arst_n) begin
		item_out_t want;
		if (!arst_n) begin
			fail_count <= 0;
		end else begin
			if (done) begin
				if (state_queue.size() == 0) begin
					if (fail_count < 10)
						$display("unexpected result hi=%h lo=%h",
							item_out.result_hi, item_out.result_lo);
					fail_count <= fail_count + 1;
				end else begin
					want = state_queue.pop_front();
					if (item_out.result_hi !== want.result_hi ||
							item_out.result_lo !== want.result_lo) begin
						if (fail_count < 10)
							$display("mismatch: hi exp %h got %h, lo exp %h got %h",
								want.result_hi, item_out.result_hi,
								want.result_lo, item_out.result_lo);
						fail_count <= fail_count + 1;
					end
				end
			end
			if (start && !busy)
				state_queue.push_back(transform_state(item_in));
		end
	end
endmodule

/* tb/sv/tb_top.sv */
module tb_top;
	timeunit 1ns;
	timeprecision 1ps;
	import artu_pkg::*;

	logic       clk;
	logic       arst_n;
	logic       start;
	logic       busy;
	logic       done;
	item_in_t   item_in;
	item_out_t  item_out;
	int         fail_count;
	int         pending;

	aes_round_transform_unit dut (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy),
		.item_in(item_in), .done(done), .item_out(item_out)
	);

	aes_transform_checker checker_i (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy),
		.item_in(item_in), .done(done), .item_out(item_out),
		.fail_count(fail_count), .pending(pending)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	initial begin
		#2000000;
		$display("CHECK FAILED");
		$finish;
	end

	function automatic logic [63:0] rand64();
		return {$urandom, $urandom};
	endfunction

	// present one item and hold it until accepted, then idle for the given gap
	task automatic send_item(input logic [2:0] kind, input logic [63:0] shi,
			input logic [63:0] slo, input logic [63:0] khi, input logic [63:0] klo,
			input int gap);
		start <= 1'b1;
		item_in <= '{kind: kind, state_hi: shi, state_lo: slo, key_hi: khi, key_lo: klo};
		@(posedge clk);
		while (busy)
			@(posedge clk);
		if (gap > 0) begin
			start <= 1'b0;
			repeat (gap) @(posedge clk);
		end
	endtask

	initial begin
		int gap;
		int burst;
		start = 1'b0;
		item_in = '0;
		arst_n = 1'b0;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: each kind on all-zero, all-one and a FIPS-197 style state
		for (int k = 0; k < 8; k++) begin
			send_item(k[2:0], '0, '0, '1, '1, 0);
			send_item(k[2:0], '1, '1, '0, '0, 1);
			send_item(k[2:0], 64'h3243f6a8885a308d, 64'h313198a2e0370734,
				64'h2b7e151628aed2a6, 64'habf7158809cf4f3c, 0);
		end

		// random, with stretches of back-to-back items
		burst = 0;
		for (int n = 0; n < 400; n++) begin
			if (burst > 0) begin
				gap = 0;
				burst--;
			end else begin
				gap = $urandom_range(0, 13);
				if ($urandom_range(0, 15) == 0)
					burst = $urandom_range(5, 20);
			end
			send_item(3'($urandom_range(0, 7)), rand64(), rand64(), rand64(), rand64(),
				gap);
		end
		start <= 1'b0;

		while (pending != 0)
			@(posedge clk);
		repeat (10) @(posedge clk);
		if (fail_count == 0)
			$display("CHECK OK");
		else
			$display("CHECK FAILED");
		$finish;
	end
endmodule
